FILE: rtl/assert_macros.svh
// Assertion macros for the checker file gpce_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define GPCE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// check a property at every clock edge, reset included
`define GPCE_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: property failed");

`endif

FILE: rtl/gpce_pkg.sv
// Types, constants and codes of the gamepad change-event block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpce_pkg;

   localparam int SLOT_COUNT   = 17;
   localparam int SLOT_BTN_LO  = 4;
   localparam int SLOT_HAT     = 12;
   localparam int SLOT_AXIS    = 13;
   localparam int REC_DEPTH    = 2;
   localparam int OUT_DEPTH    = 2;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd30;
   localparam logic [14:0] DEADZONE_RESET  = 15'd10000;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_DEADZONE  = 1'b1;

   typedef enum logic [1:0] {
      EV_BUTTON = 2'd0,
      EV_HAT    = 2'd1,
      EV_AXIS   = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic               device_present;
      logic [15:0]        digital_buttons;
      logic [63:0]        analog_buttons;
      logic signed [15:0] left_stick_x;
      logic signed [15:0] left_stick_y;
      logic signed [15:0] right_stick_x;
      logic signed [15:0] right_stick_y;
   } req_item_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic [3:0]         event_index;
      logic signed [15:0] event_value;
      logic               last_event;
   } rsp_item_type;

   // one poll with at least one change, slots in event order
   typedef struct packed {
      logic [SLOT_COUNT-1:0] change;
      logic [11:0]           buttons;
      logic [3:0]            hat;
      logic [3:0][15:0]      axes;
   } record_type;

endpackage

`default_nettype wire

FILE: rtl/gpce_fifo.sv
// Small register queue, used between the front and back ends and at the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module gpce_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gpce_front.sv
// Front end: takes a poll, shapes buttons, hat and axes, compares with the
// remembered state and writes a change record. Depends on gpce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpce_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  gpce_pkg::req_item_type req_item,
   output logic                  req_full,
   input  logic [7:0]            press_threshold,
   input  logic [14:0]           axis_deadzone,
   output logic                  rec_push,
   output gpce_pkg::record_type  rec_item,
   input  logic                  rec_full
);

   function automatic logic [15:0] shape_axis(input logic signed [15:0] raw,
                                              input logic [14:0] dz,
                                              input logic negate);
      logic signed [16:0] v;
      logic signed [16:0] lim;
      logic signed [16:0] adj;
      begin
         v   = signed'({raw[15], raw});
         lim = signed'({2'b00, dz});
         if ((v < lim) && (v > -lim)) begin
            adj = '0;
         end else begin
            adj = v[16] ? v + 17'sd1 : v;
            if (negate) begin
               adj = -adj;
            end
         end
         return adj[15:0];
      end
   endfunction

   logic [11:0]      btn_ff, btn_in;
   logic [3:0]       hat_ff, hat_in;
   logic [3:0][15:0] axis_ff, axis_in;
   logic [11:0]      fresh;
   logic [3:0]       hat;
   logic [3:0][15:0] vals;
   logic [gpce_pkg::SLOT_COUNT-1:0] change;
   logic             accept;

   assign req_full = rec_full;
   assign accept   = req_push && !req_full && req_item.device_present;

   always_comb begin
      fresh[11:8] = req_item.digital_buttons[7:4];
      for (int k = 0; k < 8; k++) begin
         fresh[k] = (req_item.analog_buttons[8*k +: 8] > press_threshold);
      end
      hat = {req_item.digital_buttons[2], req_item.digital_buttons[1],
             req_item.digital_buttons[3], req_item.digital_buttons[0]};
      vals[0] = shape_axis(req_item.left_stick_x,  axis_deadzone, 1'b0);
      vals[1] = shape_axis(req_item.left_stick_y,  axis_deadzone, 1'b1);
      vals[2] = shape_axis(req_item.right_stick_x, axis_deadzone, 1'b0);
      vals[3] = shape_axis(req_item.right_stick_y, axis_deadzone, 1'b1);

      change[gpce_pkg::SLOT_BTN_LO-1:0] = fresh[11:8] ^ btn_ff[11:8];
      change[gpce_pkg::SLOT_HAT-1:gpce_pkg::SLOT_BTN_LO] = fresh[7:0] ^ btn_ff[7:0];
      change[gpce_pkg::SLOT_HAT] = (hat != hat_ff);
      for (int k = 0; k < 4; k++) begin
         change[gpce_pkg::SLOT_AXIS + k] = (vals[k] != axis_ff[k]);
      end
   end

   always_comb begin
      rec_item.change  = change;
      rec_item.buttons = fresh;
      rec_item.hat     = hat;
      rec_item.axes    = vals;
      rec_push         = accept && (change != '0);
      btn_in           = accept ? fresh : btn_ff;
      hat_in           = accept ? hat   : hat_ff;
      axis_in          = accept ? vals  : axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_ff  <= '0;
         hat_ff  <= '0;
         axis_ff <= '0;
      end else begin
         btn_ff  <= btn_in;
         hat_ff  <= hat_in;
         axis_ff <= axis_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gpce_back.sv
// Back end: drains one change record, one event per cycle in event order
// while the result queue has room. Depends on gpce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpce_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rec_empty,
   input  gpce_pkg::record_type   rec_item,
   output logic                   rec_pop,
   input  logic                   out_full,
   output logic                   out_push,
   output gpce_pkg::rsp_item_type out_item
);

   localparam int SW = $clog2(gpce_pkg::SLOT_COUNT);

   logic [gpce_pkg::SLOT_COUNT-1:0] mask_ff, mask_in, rest;
   gpce_pkg::record_type            cur_ff, cur_in;
   logic [SW-1:0]                   sel;
   logic [3:0]                      btn_idx;
   logic [1:0]                      axis_idx;
   logic                            last;

   always_comb begin
      sel = '0;
      for (int k = gpce_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = SW'(k);
         end
      end
      rest = mask_ff & ~(gpce_pkg::SLOT_COUNT'(1) << sel);
      last = (rest == '0);
   end

   always_comb begin
      btn_idx  = '0;
      axis_idx = '0;
      out_item.last_event = last;
      priority if (sel < SW'(gpce_pkg::SLOT_BTN_LO)) begin
         btn_idx = 4'(sel + SW'(8));
         out_item.event_kind  = gpce_pkg::EV_BUTTON;
         out_item.event_index = btn_idx;
         out_item.event_value = {15'd0, cur_ff.buttons[btn_idx]};
      end else if (sel < SW'(gpce_pkg::SLOT_HAT)) begin
         btn_idx = 4'(sel - SW'(gpce_pkg::SLOT_BTN_LO));
         out_item.event_kind  = gpce_pkg::EV_BUTTON;
         out_item.event_index = btn_idx;
         out_item.event_value = {15'd0, cur_ff.buttons[btn_idx]};
      end else if (sel == SW'(gpce_pkg::SLOT_HAT)) begin
         out_item.event_kind  = gpce_pkg::EV_HAT;
         out_item.event_index = '0;
         out_item.event_value = {12'd0, cur_ff.hat};
      end else begin
         axis_idx = 2'(sel - SW'(gpce_pkg::SLOT_AXIS));
         out_item.event_kind  = gpce_pkg::EV_AXIS;
         out_item.event_index = {2'b00, axis_idx};
         out_item.event_value = cur_ff.axes[axis_idx];
      end
   end

   always_comb begin
      out_push = (mask_ff != '0) && !out_full;
      rec_pop  = !rec_empty && ((mask_ff == '0) || (out_push && last));
      mask_in  = out_push ? rest : mask_ff;
      cur_in   = cur_ff;
      if (rec_pop) begin
         mask_in = rec_item.change;
         cur_in  = rec_item;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gamepad_report_change_events.sv
// Top level of the gamepad change-event block: register port, front end,
// record queue, back end and result queue. Depends on gpce_pkg, gpce_front, gpce_fifo and gpce_back.
//
//   channel   ports                        moves
//   req       req_push / req_full          one poll per item
//   rsp       rsp_empty / rsp_pop          one change event per item
//   csr       csr_psel ... csr_prdata      press_threshold at 0, axis_deadzone at 4
//
// A poll is taken whenever the record queue has room.
// The back end gives one event per cycle while the result queue has room, so a poll
// with n changes (at most 17) gives n events; the next record follows without a gap.
// A poll's results pass the record queue, the back end and the result queue before they appear.
// A full result queue stalls the back end, then the record queue, then req_full.
// Reset clears the remembered state and both queues.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_report_change_events #(
   parameter int REC_DEPTH = gpce_pkg::REC_DEPTH,
   parameter int OUT_DEPTH = gpce_pkg::OUT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  gpce_pkg::req_item_type req_item,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output gpce_pkg::rsp_item_type rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [7:0]             threshold_ff, threshold_in;
   logic [14:0]            deadzone_ff, deadzone_in;
   logic                   csr_write;
   logic                   rec_push, rec_full, rec_pop, rec_empty;
   gpce_pkg::record_type   rec_wr, rec_rd;
   logic                   out_push, out_full;
   gpce_pkg::rsp_item_type out_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      deadzone_in  = deadzone_ff;
      unique case (csr_paddr[2])
         gpce_pkg::CSR_THRESHOLD: begin
            csr_prdata = {24'd0, threshold_ff};
            if (csr_write) begin
               threshold_in = csr_pwdata[7:0];
            end
         end
         gpce_pkg::CSR_DEADZONE: begin
            csr_prdata = {17'd0, deadzone_ff};
            if (csr_write) begin
               deadzone_in = csr_pwdata[14:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gpce_pkg::THRESHOLD_RESET;
         deadzone_ff  <= gpce_pkg::DEADZONE_RESET;
      end else begin
         threshold_ff <= threshold_in;
         deadzone_ff  <= deadzone_in;
      end
   end

   gpce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_item        (req_item),
      .req_full        (req_full),
      .press_threshold (threshold_ff),
      .axis_deadzone   (deadzone_ff),
      .rec_push        (rec_push),
      .rec_item        (rec_wr),
      .rec_full        (rec_full)
   );

   gpce_fifo #(
      .item_type (gpce_pkg::record_type),
      .DEPTH     (REC_DEPTH)
   ) u_rec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_item (rec_wr),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_item  (rec_rd),
      .empty     (rec_empty)
   );

   gpce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (rec_empty),
      .rec_item  (rec_rd),
      .rec_pop   (rec_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   gpce_fifo #(
      .item_type (gpce_pkg::rsp_item_type),
      .DEPTH     (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

FILE: rtl/gpce_checker.sv
// Port-level checks of the gamepad change-event block, bound to the top level.
// Depends on gpce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gpce_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input gpce_pkg::rsp_item_type rsp_item
);

   logic is_button;
   logic is_hat;
   logic is_axis;
   logic button_ok;
   logic hat_ok;
   logic axis_ok;

   assign is_button = !rsp_empty && (rsp_item.event_kind == gpce_pkg::EV_BUTTON);
   assign is_hat    = !rsp_empty && (rsp_item.event_kind == gpce_pkg::EV_HAT);
   assign is_axis   = !rsp_empty && (rsp_item.event_kind == gpce_pkg::EV_AXIS);
   assign button_ok = (rsp_item.event_index <= 4'd11) &&
                      ((rsp_item.event_value == 16'sd0) || (rsp_item.event_value == 16'sd1));
   assign hat_ok    = (rsp_item.event_index == 4'd0) && (rsp_item.event_value[15:4] == 12'd0);
   assign axis_ok   = (rsp_item.event_index <= 4'd3) && (rsp_item.event_value != 16'h8000);

   `GPCE_ASSERT_NORST(a_reset_clears, clock, reset |=> (rsp_empty && !req_full))
   `GPCE_ASSERT(a_kind_known, clock, reset, !rsp_empty |-> (is_button || is_hat || is_axis))
   `GPCE_ASSERT(a_button_event, clock, reset, is_button |-> button_ok)
   `GPCE_ASSERT(a_hat_event, clock, reset, is_hat |-> hat_ok)
   `GPCE_ASSERT(a_axis_event, clock, reset, is_axis |-> axis_ok)

endmodule

bind gamepad_report_change_events gpce_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: tb/gpce_event_checker.sv
// Scoreboard for the gamepad change-event block: tracks the register port, predicts
// the change events of every accepted poll and compares each popped event against them.
// Depends on gpce_pkg.
`timescale 1ns / 1ps

module gpce_event_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  gpce_pkg::req_item_type req_item,
   input  logic                   rsp_pop,
   input  logic                   rsp_empty,
   input  gpce_pkg::rsp_item_type rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output int                     error_count,
   output int                     pending_count
);

   localparam logic [2:0] THRESHOLD_ADDR = {gpce_pkg::CSR_THRESHOLD, 2'b00};
   localparam logic [2:0] DEADZONE_ADDR  = {gpce_pkg::CSR_DEADZONE, 2'b00};

   gpce_pkg::rsp_item_type expected_events [$];
   logic [7:0]             press_threshold;
   logic [14:0]            axis_deadzone;
   logic [11:0]            held_buttons;
   logic [3:0]             held_hat;
   logic signed [15:0]     held_axes [4];

   task automatic predict_events(input gpce_pkg::req_item_type poll);
      gpce_pkg::rsp_item_type batch [gpce_pkg::SLOT_COUNT];
      gpce_pkg::rsp_item_type ev;
      logic [11:0]  fresh;
      logic [3:0]   hat;
      int           raw [4];
      int           shaped;
      int           dz;
      int           count;
      int           k;
      int           n;
      count = 0;
      if (poll.device_present) begin
         fresh = {poll.digital_buttons[7:4], 8'h00};
         for (k = 0; k < 8; k++)
            if (poll.analog_buttons[8*k +: 8] > press_threshold) fresh[k] = 1'b1;
         for (n = 0; n < 12; n++) begin
            k = (n < 4) ? n + 8 : n - 4;
            if (fresh[k] != held_buttons[k]) begin
               ev.event_kind  = gpce_pkg::EV_BUTTON;
               ev.event_index = k[3:0];
               ev.event_value = {15'd0, fresh[k]};
               ev.last_event  = 1'b0;
               batch[count] = ev;
               count++;
            end
         end
         held_buttons = fresh;

         hat = {poll.digital_buttons[2], poll.digital_buttons[1],
                poll.digital_buttons[3], poll.digital_buttons[0]};
         if (hat != held_hat) begin
            ev.event_kind  = gpce_pkg::EV_HAT;
            ev.event_index = 4'd0;
            ev.event_value = {12'd0, hat};
            ev.last_event  = 1'b0;
            batch[count] = ev;
            count++;
         end
         held_hat = hat;

         raw[0] = $signed(poll.left_stick_x);
         raw[1] = $signed(poll.left_stick_y);
         raw[2] = $signed(poll.right_stick_x);
         raw[3] = $signed(poll.right_stick_y);
         dz = axis_deadzone;
         for (k = 0; k < 4; k++) begin
            shaped = raw[k];
            if (shaped < dz && shaped > -dz) begin
               shaped = 0;
            end else begin
               if (shaped < 0) shaped = shaped + 1;
               if (k % 2 == 1) shaped = -shaped;
            end
            if (shaped[15:0] != held_axes[k]) begin
               ev.event_kind  = gpce_pkg::EV_AXIS;
               ev.event_index = k[3:0];
               ev.event_value = shaped[15:0];
               ev.last_event  = 1'b0;
               batch[count] = ev;
               count++;
            end
            held_axes[k] = shaped[15:0];
         end

         for (n = 0; n < count; n++) begin
            ev = batch[n];
            ev.last_event = (n == count - 1);
            expected_events.push_back(ev);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      gpce_pkg::rsp_item_type want;
      int           faults;
      int           k;
      faults = 0;
      if (reset) begin
         expected_events.delete();
         press_threshold = gpce_pkg::THRESHOLD_RESET;
         axis_deadzone   = gpce_pkg::DEADZONE_RESET;
         held_buttons    = '0;
         held_hat        = '0;
         for (k = 0; k < 4; k++) held_axes[k] = '0;
         pending_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == THRESHOLD_ADDR) press_threshold = csr_pwdata[7:0];
            else if (csr_paddr == DEADZONE_ADDR) axis_deadzone = csr_pwdata[14:0];
         end

         if (rsp_pop && !rsp_empty) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event: expected none, %s %0d index %0d value %0d last %0d",
                        $time, "actual kind", rsp_item.event_kind, rsp_item.event_index,
                        $signed(rsp_item.event_value), rsp_item.last_event);
               faults++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_item.event_kind !== want.event_kind) begin
                  $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                           $time, want.event_kind, rsp_item.event_kind);
                  faults++;
               end
               if (rsp_item.event_index !== want.event_index) begin
                  $display("%0t: event_index mismatch: expected %0d, actual %0d",
                           $time, want.event_index, rsp_item.event_index);
                  faults++;
               end
               if (rsp_item.event_value !== want.event_value) begin
                  $display("%0t: event_value mismatch: expected %0d, actual %0d",
                           $time, $signed(want.event_value), $signed(rsp_item.event_value));
                  faults++;
               end
               if (rsp_item.last_event !== want.last_event) begin
                  $display("%0t: last_event mismatch: expected %0d, actual %0d",
                           $time, want.last_event, rsp_item.last_event);
                  faults++;
               end
            end
         end

         if (req_push && !req_full) predict_events(req_item);
         pending_count <= expected_events.size();
      end
      error_count <= error_count + faults;
   end

endmodule

FILE: tb/testbench.sv
// Top of the gamepad change-event testbench: clock, reset, poll stimulus, register
// writes and event draining, with the verdict taken from gpce_event_checker.
// Depends on gpce_pkg, gpce_event_checker and gamepad_report_change_events.
`timescale 1ns / 1ps

module testbench;

   localparam int         CYCLE_LIMIT    = 600000;
   localparam int         PHASE_ITEMS    = 58;
   localparam logic [2:0] THRESHOLD_ADDR = {gpce_pkg::CSR_THRESHOLD, 2'b00};
   localparam logic [2:0] DEADZONE_ADDR  = {gpce_pkg::CSR_DEADZONE, 2'b00};

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_push    = 1'b0;
   gpce_pkg::req_item_type req_item    = '0;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop     = 1'b0;
   gpce_pkg::rsp_item_type rsp_item;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [2:0]             csr_paddr   = '0;
   logic [31:0]            csr_pwdata  = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int                     error_count;
   int                     pending_count;
   int                     cycle_count        = 0;
   int                     sender_idle_pct    = 0;
   int                     receiver_stall_pct = 0;
   logic [7:0]             cur_threshold      = gpce_pkg::THRESHOLD_RESET;
   logic [14:0]            cur_deadzone       = gpce_pkg::DEADZONE_RESET;
   gpce_pkg::req_item_type last_poll          = '0;

   gamepad_report_change_events dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_item    (req_item),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gpce_event_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_item      (req_item),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_item      (rsp_item),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) rsp_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);

   function automatic gpce_pkg::req_item_type make_poll(input logic present,
                                                        input logic [15:0] digital,
                                                        input logic [63:0] analog, input int lx,
                                                        input int ly, input int rx, input int ry);
      gpce_pkg::req_item_type poll;
      poll.device_present  = present;
      poll.digital_buttons = digital;
      poll.analog_buttons  = analog;
      poll.left_stick_x    = lx[15:0];
      poll.left_stick_y    = ly[15:0];
      poll.right_stick_x   = rx[15:0];
      poll.right_stick_y   = ry[15:0];
      return poll;
   endfunction

   function automatic logic [15:0] pick_stick();
      int dz;
      int v;
      dz = cur_deadzone;
      case ($urandom_range(0, 7))
         0:       v = -32768;
         1:       v = 32767;
         2:       v = dz;
         3:       v = -dz;
         4:       v = dz - 1;
         5:       v = 1 - dz;
         6:       v = $urandom;
         default: v = 0;
      endcase
      return v[15:0];
   endfunction

   function automatic logic [7:0] pick_byte();
      int v;
      case ($urandom_range(0, 5))
         0:       v = cur_threshold;
         1:       v = cur_threshold + 1;
         2:       v = 0;
         3:       v = 255;
         default: v = $urandom;
      endcase
      return v[7:0];
   endfunction

   function automatic gpce_pkg::req_item_type random_poll(input gpce_pkg::req_item_type prev);
      gpce_pkg::req_item_type poll;
      int           k;
      poll = prev;
      case ($urandom_range(0, 9))
         0: begin
            poll = make_poll(1'b0, 16'($urandom), {$urandom, $urandom}, $urandom, $urandom,
                             $urandom, $urandom);
         end
         1, 2, 3: begin
            poll.device_present = 1'b1;
            case ($urandom_range(0, 3))
               0: poll.digital_buttons[$urandom_range(0, 15)] ^= 1'b1;
               1: poll.analog_buttons[8*$urandom_range(0, 7) +: 8] = pick_byte();
               2: poll.left_stick_x = pick_stick();
               default: poll.right_stick_y = pick_stick();
            endcase
         end
         default: begin
            poll.device_present  = 1'b1;
            poll.digital_buttons = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               poll.analog_buttons = {$urandom, $urandom};
            end else begin
               for (k = 0; k < 8; k++) poll.analog_buttons[8*k +: 8] = pick_byte();
            end
            poll.left_stick_x  = pick_stick();
            poll.left_stick_y  = pick_stick();
            poll.right_stick_x = pick_stick();
            poll.right_stick_y = pick_stick();
         end
      endcase
      return poll;
   endfunction

   task automatic send_poll(input gpce_pkg::req_item_type poll);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= poll;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == THRESHOLD_ADDR) cur_threshold = data[7:0];
      else cur_deadzone = data[14:0];
   endtask

   task automatic set_config(input int threshold, input int deadzone);
      wait_quiet();
      write_csr(THRESHOLD_ADDR, threshold);
      write_csr(DEADZONE_ADDR, deadzone);
   endtask

   initial begin
      int k;
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_poll(make_poll(1'b0, 16'hFFFF, '1, -32768, -32768, 32767, 32767));
      send_poll(make_poll(1'b1, 16'h00FF, '1, -32768, -32768, 32767, 32767));
      send_poll(make_poll(1'b1, 16'h00FF, '1, -32768, -32768, 32767, 32767));
      send_poll(make_poll(1'b1, 16'hFF00, 64'h1F1E_1F1E_1F1E_1F1E, 9999, -9999, 10000,
                          -10000));
      send_poll(make_poll(1'b0, 16'h0000, '0, 0, 0, 0, 0));
      for (k = 0; k < 8; k++) send_poll(make_poll(1'b1, 16'h0001 << k, '0, 0, 0, 0, 0));
      send_poll(make_poll(1'b1, 16'h0003, '0, 0, 0, 0, 0));
      send_poll(make_poll(1'b1, 16'h000C, '0, 0, 0, 0, 0));
      send_poll(make_poll(1'b1, 16'h0000, '0, 32767, 32767, -32768, -32768));
      send_poll(make_poll(1'b1, 16'h0000, '0, -10001, 10001, -1, 1));
      send_poll(make_poll(1'b1, 16'h0000, '0, 0, 0, 0, 0));

      set_config(0, 0);
      send_poll(make_poll(1'b1, 16'h0000, 64'h0001_0001_0001_0001, 0, -1, 1, -32768));
      send_poll(make_poll(1'b1, 16'h0000, 64'h0100_0100_0100_0100, 1, 0, -1, 32767));
      set_config(255, 32767);
      send_poll(make_poll(1'b1, 16'h0000, '1, 32767, -32767, 32766, -32768));
      send_poll(make_poll(1'b1, 16'h0000, '0, -32766, 32766, 0, -1));

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               set_config(255, 32767);
            end
            1: begin
               sender_idle_pct    = 82;
               receiver_stall_pct = 0;
               set_config($urandom_range(1, 254), $urandom_range(1, 32766));
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 82;
               set_config(0, 0);
            end
            default: begin
               sender_idle_pct    = 11;
               receiver_stall_pct = 11;
               set_config(gpce_pkg::THRESHOLD_RESET, gpce_pkg::DEADZONE_RESET);
            end
         endcase
         repeat (PHASE_ITEMS) begin
            last_poll = random_poll(last_poll);
            send_poll(last_poll);
         end
      end

      req_push <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gpce_pkg.sv
rtl/gpce_fifo.sv
rtl/gpce_front.sv
rtl/gpce_back.sv
rtl/gamepad_report_change_events.sv
rtl/gpce_checker.sv
tb/gpce_event_checker.sv
tb/testbench.sv
